// ===== rtl/cvw_pkg.sv =====
package cvw_pkg;

    // Field and datapath widths, fixed by the item format.
    localparam int PIX_W   = 16;
    localparam int COEF_W  = 16;
    localparam int CFG_W   = 64;
    localparam int CNT_W   = 7;
    localparam int POS_W   = 6;
    localparam int PROD_W  = 32;
    localparam int ROW_W   = 34;
    localparam int SUM_W   = 36;
    localparam int COEF_ROWS = 4;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W   = 2 * POS_W + SUM_W;

    localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(6);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_SIZE = 3'd0,
        CFG_COEF_ROW0  = 3'd1,
        CFG_COEF_ROW1  = 3'd2,
        CFG_COEF_ROW2  = 3'd3,
        CFG_COEF_ROW3  = 3'd4
    } t_cfg_idx;

    // Per-pixel side information carried along the pipeline.
    typedef struct packed {
        logic             result;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [POS_W-1:0]        col;
        logic [POS_W-1:0]        row;
        logic                    last;
    } t_res;

endpackage

// ===== rtl/cvw_ram.sv =====
module cvw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cvw_window.sv =====
module cvw_window
    import cvw_pkg::*;
#(
    parameter int KSIZE    = 4,
    parameter int MAX_SIZE = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_acc,
    input  logic [PIX_W-1:0]                   i_pixel,
    input  logic [CNT_W-1:0]                   i_col,
    input  t_tag                               i_tag,
    output logic                               o_valid,
    output t_tag                               o_tag,
    output logic [KSIZE*KSIZE-1:0][PIX_W-1:0]  o_window
);

    localparam int AW = $clog2(MAX_SIZE);

    logic                              r_s1_valid;
    logic [PIX_W-1:0]                  r_s1_pixel;
    logic [AW-1:0]                     r_s1_addr;
    logic                              r_s1_inrange;
    t_tag                              r_s1_tag;
    logic                              r_s2_valid;
    t_tag                              r_s2_tag;
    logic [KSIZE*KSIZE-1:0][PIX_W-1:0] r_win;
    logic [KSIZE-1:0][PIX_W-1:0]       column;
    logic                              acc_inrange;

    assign acc_inrange = (32'(i_col) < 32'(MAX_SIZE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_acc;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_pixel   <= i_pixel;
            r_s1_addr    <= AW'(i_col);
            r_s1_inrange <= acc_inrange;
            r_s1_tag     <= i_tag;
        end
        if (i_en) begin
            r_s2_tag <= r_s1_tag;
        end
    end

    // The line store is read when a beat is accepted and written back from the stage-1
    // registers when the pipeline advances. Consecutive pixels always sit in different
    // columns, so a read never meets a pending write to the same entry.
    generate
        if (KSIZE > 1) begin : g_lines
            localparam int LW = PIX_W * (KSIZE - 1);
            logic [LW-1:0] rdata;
            logic [LW-1:0] wdata;

            cvw_ram #(
                .WIDTH (LW),
                .DEPTH (MAX_SIZE)
            ) u_line_ram (
                .i_clk   (i_clk),
                .i_we    (i_en && r_s1_valid && r_s1_inrange),
                .i_waddr (r_s1_addr),
                .i_wdata (wdata),
                .i_re    (i_acc),
                .i_raddr (AW'(i_col)),
                .o_rdata (rdata)
            );

            always_comb begin
                column[KSIZE-1] = r_s1_pixel;
                for (int k = 0; k < KSIZE - 1; k++) begin
                    column[k] = r_s1_inrange ? rdata[k*PIX_W +: PIX_W] : '0;
                end
                for (int k = 0; k < KSIZE - 1; k++) begin
                    wdata[k*PIX_W +: PIX_W] = column[k+1];
                end
            end
        end else begin : g_no_lines
            assign column[0] = r_s1_pixel;
        end
    endgenerate

    // Each row of the window shifts left by one and takes the new column entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_en && r_s1_valid) begin
            for (int r = 0; r < KSIZE; r++) begin
                for (int c = 0; c < KSIZE - 1; c++) begin
                    r_win[r*KSIZE+c] <= r_win[r*KSIZE+c+1];
                end
                r_win[r*KSIZE+KSIZE-1] <= column[r];
            end
        end
    end

    assign o_valid  = r_s2_valid;
    assign o_tag    = r_s2_tag;
    assign o_window = r_win;

endmodule

// ===== rtl/cvw_mac.sv =====
module cvw_mac
    import cvw_pkg::*;
#(
    parameter int KSIZE = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  t_tag                               i_tag,
    input  logic [KSIZE*KSIZE-1:0][PIX_W-1:0]  i_window,
    input  logic [COEF_ROWS-1:0][CFG_W-1:0]    i_coef,
    output logic                               o_valid,
    output t_tag                               o_tag,
    output logic signed [SUM_W-1:0]            o_sum
);

    logic signed [PROD_W-1:0] n_prod [KSIZE*KSIZE];
    logic signed [PROD_W-1:0] r_prod [KSIZE*KSIZE];
    logic signed [ROW_W-1:0]  n_row  [KSIZE];
    logic signed [ROW_W-1:0]  r_row  [KSIZE];
    logic signed [SUM_W-1:0]  n_total;
    logic signed [SUM_W-1:0]  r_total;
    logic                     r_s3_valid;
    logic                     r_s4_valid;
    logic                     r_s5_valid;
    t_tag                     r_s3_tag;
    t_tag                     r_s4_tag;
    t_tag                     r_s5_tag;

    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
                n_prod[r*KSIZE+c] = $signed(i_window[r*KSIZE+c]) *
                                    $signed(i_coef[r][c*COEF_W +: COEF_W]);
            end
        end
    end

    always_comb begin
        logic signed [ROW_W-1:0] acc;
        for (int r = 0; r < KSIZE; r++) begin
            acc = '0;
            for (int c = 0; c < KSIZE; c++) begin
                acc = acc + ROW_W'(r_prod[r*KSIZE+c]);
            end
            n_row[r] = acc;
        end
    end

    always_comb begin
        n_total = '0;
        for (int r = 0; r < KSIZE; r++) begin
            n_total = n_total + SUM_W'(r_row[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= i_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod;
            r_row    <= n_row;
            r_total  <= n_total;
            r_s3_tag <= i_tag;
            r_s4_tag <= r_s3_tag;
            r_s5_tag <= r_s4_tag;
        end
    end

    assign o_valid = r_s5_valid;
    assign o_tag   = r_s5_tag;
    assign o_sum   = r_total;

endmodule

// ===== rtl/conv2d_valid_window_unit.sv =====
// A result beat reaches the master port through the line-store read, window shift,
// multiply, row-sum, total and output registers.
// Throughput: one pixel per cycle while the output skid entry is free; the line-store
// RAM is read and written once per pixel and the 4x4 multiply-add is fully pipelined.
// A two-entry output buffer holds the slave side ready until both entries are full.
// Reset (synchronous, active low): counters, window and valid bits clear, the image
// size returns to 6 and all coefficients to zero; the line store is not cleared.
module conv2d_valid_window_unit
    import cvw_pkg::*;
#(
    parameter int KSIZE    = 4,
    parameter int MAX_SIZE = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,  // [15:0] pixel
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata,  // [5:0] out_row, [11:6] out_col,
                                                  // [47:12] sum
    output logic                 o_m_axis_tlast,  // frame_last
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] KS_C  = CNT_W'(KSIZE);
    localparam logic [CNT_W-1:0] KM1_C = CNT_W'(KSIZE - 1);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'((MAX_SIZE > CNT_MAX) ? CNT_MAX : MAX_SIZE);

    logic [CNT_W-1:0]                  r_image_size;
    logic [COEF_ROWS-1:0][CFG_W-1:0]   r_coef;
    logic [CNT_W-1:0]                  r_row;
    logic [CNT_W-1:0]                  r_col;
    logic [CNT_W-1:0]                  n_row;
    logic [CNT_W-1:0]                  n_col;
    logic [CNT_W-1:0]                  size_eff;
    logic                              en;
    logic                              acc;
    t_tag                              acc_tag;
    logic                              win_valid;
    t_tag                              win_tag;
    logic [KSIZE*KSIZE-1:0][PIX_W-1:0] win_data;
    logic                              mac_valid;
    t_tag                              mac_tag;
    logic signed [SUM_W-1:0]           mac_sum;
    logic                              new_res;
    t_res                              res;
    logic                              r_out_valid;
    t_res                              r_out;
    logic                              r_skid_valid;
    t_res                              r_skid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= SIZE_RESET;
            r_coef       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IMAGE_SIZE: r_image_size <= i_cfg_wdata[CNT_W-1:0];
                CFG_COEF_ROW0:  r_coef[0]    <= i_cfg_wdata;
                CFG_COEF_ROW1:  r_coef[1]    <= i_cfg_wdata;
                CFG_COEF_ROW2:  r_coef[2]    <= i_cfg_wdata;
                CFG_COEF_ROW3:  r_coef[3]    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        size_eff = r_image_size;
        priority if (r_image_size < KS_C) begin
            size_eff = KS_C;
        end else if (r_image_size > MAX_C) begin
            size_eff = MAX_C;
        end else begin
            size_eff = r_image_size;
        end
    end

    // The whole pipeline moves while the output skid entry is free.
    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;
    assign acc             = i_s_axis_tvalid && en;

    // A counter at or past the last position ends the row or frame, which also
    // covers a size that was lowered in the middle of a frame.
    always_comb begin
        if (({1'b0, r_col} + 1'b1) >= {1'b0, size_eff}) begin
            n_col = '0;
            n_row = (({1'b0, r_row} + 1'b1) >= {1'b0, size_eff}) ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign acc_tag.result = (r_row < size_eff) && (r_col < size_eff) &&
                            (r_row >= KM1_C) && (r_col >= KM1_C);
    assign acc_tag.last   = (r_row == size_eff - 1'b1) && (r_col == size_eff - 1'b1);
    assign acc_tag.row    = POS_W'(r_row - KM1_C);
    assign acc_tag.col    = POS_W'(r_col - KM1_C);

    cvw_window #(
        .KSIZE    (KSIZE),
        .MAX_SIZE (MAX_SIZE)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_acc    (acc),
        .i_pixel  (i_s_axis_tdata),
        .i_col    (r_col),
        .i_tag    (acc_tag),
        .o_valid  (win_valid),
        .o_tag    (win_tag),
        .o_window (win_data)
    );

    cvw_mac #(
        .KSIZE (KSIZE)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (win_valid),
        .i_tag    (win_tag),
        .i_window (win_data),
        .i_coef   (r_coef),
        .o_valid  (mac_valid),
        .o_tag    (mac_tag),
        .o_sum    (mac_sum)
    );

    assign new_res  = en && mac_valid && mac_tag.result;
    assign res.sum  = mac_sum;
    assign res.col  = mac_tag.col;
    assign res.row  = mac_tag.row;
    assign res.last = mac_tag.last;

    // Output register plus one skid entry. New results arrive only while the
    // skid entry is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= new_res;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= new_res;
        end else if (new_res) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_out_valid && i_m_axis_tready) || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (new_res) begin
            r_skid <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.sum, r_out.col, r_out.row};
    assign o_m_axis_tlast  = r_out.last;

endmodule
